@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the DHCP options parser.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/dhcpopt_pkg.sv @@
// Package for the DHCP options TLV parser: payload structs, phase enum, codes.
// No dependencies.
`default_nettype none

package dhcpopt_pkg;

    // Option codes
    localparam logic [7:0] OPT_PAD         = 8'h00;
    localparam logic [7:0] OPT_END         = 8'hff;
    localparam logic [7:0] OPT_SUBNET_MASK = 8'h01;

    // Value bytes counted per option, saturating here
    localparam logic [2:0] VIDX_SAT = 3'd4;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        mask_found;
        logic [31:0] subnet_mask;
        logic        ended_cleanly;
        logic        cut_inside_option;
    } out_item_t;

endpackage

`default_nettype wire

@@ src/dhcpopt_walker.sv @@
// TLV walker: per-byte parse state and the result decision for each transfer.
// Depends on dhcpopt_pkg.
`default_nettype none

module dhcpopt_walker
    import dhcpopt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      take,
    input  wire in_item_t  item,
    output logic           res_valid,
    output out_item_t      res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  left_reg, left_next;
    logic [2:0]  vidx_reg, vidx_next;
    logic [31:0] mask_reg, mask_next;
    logic        seen_reg, seen_next;
    logic        closed_reg, closed_next;

    // Next state and result for the byte on the input
    always_comb
    begin
        logic [31:0] placed;
        logic        clean;

        placed = '0;
        clean  = 1'b0;
        res_valid = 1'b0;

        // A first byte starts from the reset state
        if (item.first_byte)
        begin
            phase_next  = PH_CODE;
            code_next   = '0;
            left_next   = '0;
            vidx_next   = '0;
            mask_next   = '0;
            seen_next   = 1'b0;
            closed_next = 1'b0;
        end
        else
        begin
            phase_next  = phase_reg;
            code_next   = code_reg;
            left_next   = left_reg;
            vidx_next   = vidx_reg;
            mask_next   = mask_reg;
            seen_next   = seen_reg;
            closed_next = closed_reg;
        end

        if (!closed_next)
        begin
            unique case (phase_next)
                PH_LEN:
                begin
                    left_next = item.data_byte;
                    vidx_next = '0;
                    if (code_next == OPT_SUBNET_MASK)
                    begin
                        mask_next = '0;
                        seen_next = 1'b1;
                    end
                    phase_next = (item.data_byte == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE:
                begin
                    unique case (vidx_next[1:0])
                        2'd0: placed = {item.data_byte, 24'd0};
                        2'd1: placed = {8'd0, item.data_byte, 16'd0};
                        2'd2: placed = {16'd0, item.data_byte, 8'd0};
                        2'd3: placed = {24'd0, item.data_byte};
                    endcase
                    if (code_next == OPT_SUBNET_MASK && vidx_next < VIDX_SAT)
                        mask_next = mask_next | placed;
                    if (vidx_next < VIDX_SAT)
                        vidx_next = vidx_next + 3'd1;
                    left_next = left_next - 8'd1;
                    if (left_next == 8'd0)
                        phase_next = PH_CODE;
                end
                default:
                begin
                    // Expecting a code (also covers a stray phase value)
                    phase_next = PH_CODE;
                    if (item.data_byte == OPT_END)
                    begin
                        closed_next = 1'b1;
                        res_valid   = 1'b1;
                        clean       = 1'b1;
                    end
                    else if (item.data_byte != OPT_PAD)
                    begin
                        code_next  = item.data_byte;
                        phase_next = PH_LEN;
                    end
                end
            endcase

            // Buffer runs out before the end option
            if (item.last_byte && !res_valid)
            begin
                closed_next = 1'b1;
                res_valid   = 1'b1;
            end
        end

        res.mask_found        = seen_next;
        res.subnet_mask       = seen_next ? mask_next : 32'd0;
        res.ended_cleanly     = clean;
        res.cut_inside_option = !clean && (phase_next != PH_CODE);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CODE;
            code_reg   <= '0;
            left_reg   <= '0;
            vidx_reg   <= '0;
            mask_reg   <= '0;
            seen_reg   <= 1'b0;
            closed_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            left_reg   <= left_next;
            vidx_reg   <= vidx_next;
            mask_reg   <= mask_next;
            seen_reg   <= seen_next;
            closed_reg <= closed_next;
        end
    end

endmodule

`default_nettype wire

@@ src/dhcpopt_out_skid.sv @@
// Result register with a skid entry, so the input side waits only while the skid entry is full.
// Depends on dhcpopt_pkg.
`default_nettype none

module dhcpopt_out_skid
    import dhcpopt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_data,
    output logic           space,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_reg, main_next;
    out_item_t skid_reg, skid_next;
    logic      pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Refill the main entry from skid first, then from the walker
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

@@ src/dhcp_option_tlv_parser.sv @@
// DHCP options TLV parser, top level.
// The result for the byte that ends the list is registered before it appears on out_data.
// Throughput: one options byte per cycle, except while the result skid entry is full.
// A two-entry result register keeps input transfers going while a result waits.
// Reset (rst_n, async, active low) clears the parse state and empties the result register.
// Depends on dhcpopt_pkg, dhcpopt_walker, dhcpopt_out_skid, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dhcp_option_tlv_parser
    import dhcpopt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      take;
    logic      res_valid;
    out_item_t res;

    assign take = in_valid && in_ready;

    dhcpopt_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    dhcpopt_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_data (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Checks
    `ASSERT_IMPL(a_stall_only_when_full, !in_ready, out_valid)
    `ASSERT_NEXT(a_single_byte_packet, take && in_data.first_byte && in_data.last_byte, out_valid)
    `ASSERT_IMPL(a_clean_not_cut, out_valid, !(out_data.ended_cleanly && out_data.cut_inside_option))
    `ASSERT_IMPL(a_no_mask_zero, out_valid && !out_data.mask_found, out_data.subnet_mask == 32'd0)

endmodule

`default_nettype wire

@@ sim/dhcp_option_tlv_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dhcp_option_tlv_parser: directed and random options
// streams, with a scoreboard class that walks each TLV list. Depends on dhcpopt_pkg.
module dhcp_option_tlv_parser_tb;

    import dhcpopt_pkg::*;

    localparam int RANDOM_ITEMS     = 750;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_REPORT_LINES = 100;

    typedef logic [7:0] octet_q_t[$];

    typedef enum logic [1:0] {
        RX_STREAM  = 2'd0,
        RX_COIN    = 2'd1,
        RX_STARVED = 2'd2,
        RX_PATTERN = 2'd3
    } rx_mode_t;

    // Walks the options list byte by byte and keeps the per-packet summaries still owed
    class mask_scoreboard;
        phase_t      walk_phase;
        logic [7:0]  cur_code;
        logic [7:0]  skip_left;
        logic [2:0]  val_count;
        logic [31:0] mask_acc;
        bit          mask_met;
        bit          closed;
        out_item_t   awaited_summaries[$];
        int          mismatch_count;

        function new();
            clear_packet();
            mismatch_count = 0;
        endfunction

        function void clear_packet();
            walk_phase = PH_CODE;
            cur_code   = 8'd0;
            skip_left  = 8'd0;
            val_count  = 3'd0;
            mask_acc   = 32'd0;
            mask_met   = 1'b0;
            closed     = 1'b0;
        endfunction

        function void owe_summary(bit clean, bit cut);
            out_item_t s;
            s.mask_found        = mask_met;
            s.subnet_mask       = mask_met ? mask_acc : 32'd0;
            s.ended_cleanly     = clean;
            s.cut_inside_option = !clean && cut;
            awaited_summaries.push_back(s);
        endfunction

        function int outstanding();
            return awaited_summaries.size();
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT_LINES)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // One accepted options byte
        function void note_byte(in_item_t item);
            logic [7:0] b;
            int         sh;
            b = item.data_byte;
            if (item.first_byte)
                clear_packet();
            if (closed)
                return;
            case (walk_phase)
                PH_LEN:
                begin
                    skip_left = b;
                    val_count = 3'd0;
                    if (cur_code == OPT_SUBNET_MASK)
                    begin
                        mask_acc = 32'd0;
                        mask_met = 1'b1;
                    end
                    walk_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (cur_code == OPT_SUBNET_MASK && val_count < VIDX_SAT)
                    begin
                        sh = 24 - 8 * int'(val_count);
                        mask_acc = mask_acc | (32'(b) << sh);
                    end
                    if (val_count < VIDX_SAT)
                        val_count = val_count + 3'd1;
                    skip_left = skip_left - 8'd1;
                    if (skip_left == 8'd0)
                        walk_phase = PH_CODE;
                end
                default:
                begin
                    // a stray phase is read as expecting a code
                    walk_phase = PH_CODE;
                    if (b == OPT_END)
                    begin
                        closed = 1'b1;
                        owe_summary(1'b1, 1'b0);
                        return;
                    end
                    if (b != OPT_PAD)
                    begin
                        cur_code   = b;
                        walk_phase = PH_LEN;
                    end
                end
            endcase
            if (item.last_byte)
            begin
                closed = 1'b1;
                owe_summary(1'b0, walk_phase != PH_CODE);
            end
        endfunction

        // One accepted result against the oldest summary owed
        task check_result(out_item_t got);
            out_item_t want;
            if (awaited_summaries.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = awaited_summaries.pop_front();
            if (got.mask_found !== want.mask_found)
                report_mismatch($sformatf("mask_found %b, want %b",
                                          got.mask_found, want.mask_found));
            if (got.subnet_mask !== want.subnet_mask)
                report_mismatch($sformatf("subnet_mask %h, want %h",
                                          got.subnet_mask, want.subnet_mask));
            if (got.ended_cleanly !== want.ended_cleanly)
                report_mismatch($sformatf("ended_cleanly %b, want %b",
                                          got.ended_cleanly, want.ended_cleanly));
            if (got.cut_inside_option !== want.cut_inside_option)
                report_mismatch($sformatf("cut_inside_option %b, want %b",
                                          got.cut_inside_option, want.cut_inside_option));
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    mask_scoreboard sb = new();

    int burst_left     = 0;
    bit gapless        = 1'b0;
    int bytes_offered  = 0;
    int quiet_cycles   = 0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    dhcp_option_tlv_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock and reset
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Offer one byte and hold it until the transfer; bursts with random gaps
    task automatic offer(input in_item_t item);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (!gapless && $urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // First flag on the opening byte, last flag on the closing one if asked
    task automatic send_packet(input octet_q_t body, input bit mark_last);
        in_item_t item;
        for (int i = 0; i < body.size(); i++)
        begin
            item.data_byte  = body[i];
            item.first_byte = (i == 0);
            item.last_byte  = mark_last && (i == body.size() - 1);
            offer(item);
            bytes_offered++;
        end
    endtask

    // Bytes after a packet has closed, no first flag
    task automatic send_trailing(input int count);
        in_item_t item;
        for (int i = 0; i < count; i++)
        begin
            item.data_byte  = 8'($urandom_range(0, 255));
            item.first_byte = 1'b0;
            item.last_byte  = ($urandom_range(0, 2) == 0);
            offer(item);
        end
    endtask

    // Let the monitor note the last transfer before the count is read, then idle until no summaries are owed
    task automatic idle_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random option list: pads, mask options of varied length, other codes
    function automatic octet_q_t random_options(input int max_opts);
        octet_q_t q;
        int       n_opts;
        int       len;
        int       pick;
        n_opts = $urandom_range(0, max_opts);
        for (int i = 0; i < n_opts; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                q.push_back(OPT_PAD);
            else
            begin
                if (pick < 5)
                begin
                    q.push_back(OPT_SUBNET_MASK);
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 4;
                end
                else
                begin
                    q.push_back(8'($urandom_range(2, 254)));
                    len = $urandom_range(0, 12);
                end
                q.push_back(8'(len));
                repeat (len) q.push_back(8'($urandom_range(0, 255)));
            end
        end
        return q;
    endfunction

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: random stall modes that change from time to time, one long hold-off
    initial
    begin
        rx_mode_t mode;
        int       tick;
        tick = 0;
        wait (rst_n);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            repeat ($urandom_range(20, 120))
            begin
                @(posedge clk);
                tick++;
                if (long_hold_req && !long_hold_done)
                begin
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge clk);
                    long_hold_done <= 1'b1;
                end
                case (mode)
                    RX_STREAM:  out_ready <= 1'b1;
                    RX_COIN:    out_ready <= $urandom_range(0, 1);
                    RX_STARVED: out_ready <= ($urandom_range(0, 3) == 0);
                    default:    out_ready <= ((tick % 9) >= 3);
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin
        octet_q_t body;
        int       pick;
        int       k;
        in_item_t item;

        wait (rst_n);
        @(posedge clk);

        // Directed: end with first and last on one byte, lone pad, cut after a code
        send_packet('{OPT_END}, 1'b1);
        send_packet('{OPT_PAD}, 1'b1);
        send_packet('{OPT_SUBNET_MASK}, 1'b1);
        // full mask closed by the end option, then ignored bytes until the next packet
        send_packet('{OPT_SUBNET_MASK, 8'd4, 8'hff, 8'h00, 8'h80, 8'h7f, OPT_END}, 1'b0);
        item.data_byte  = 8'h5a;
        item.first_byte = 1'b0;
        item.last_byte  = 1'b0;
        offer(item);
        item.data_byte  = OPT_END;
        item.last_byte  = 1'b1;
        offer(item);
        // short mask, low bytes read as zero
        send_packet('{OPT_SUBNET_MASK, 8'd2, 8'hc3, 8'h3c, OPT_PAD}, 1'b1);
        // long mask, extra value bytes skipped
        send_packet('{OPT_SUBNET_MASK, 8'd5, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, OPT_END},
                    1'b0);
        // mask cut off inside its value bytes
        send_packet('{OPT_SUBNET_MASK, 8'd4, 8'hde, 8'had}, 1'b1);

        idle_until_drained();

        // Long hold-off on the result side while one-byte packets keep coming
        long_hold_req <= 1'b1;
        gapless = 1'b1;
        repeat (24) send_packet('{OPT_END}, 1'b1);
        gapless = 1'b0;

        // Random packets, mostly well-formed
        bytes_offered = 0;
        while (bytes_offered < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 15) == 0)
                gapless = !gapless;
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // closed by the end option, sometimes with trailing bytes
                body = random_options(5);
                body.push_back(OPT_END);
                send_packet(body, $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0)
                    send_trailing($urandom_range(1, 3));
            end
            else if (pick < 80)
            begin
                // buffer runs out somewhere in the list
                body = random_options(6);
                body.push_back(OPT_END);
                k = $urandom_range(0, body.size() - 1);
                body = body[0:k];
                send_packet(body, 1'b1);
            end
            else if (pick < 88)
            begin
                // never closed; the next first byte restarts the walk
                body = random_options(4);
                if (body.size() == 0)
                    body.push_back(OPT_PAD);
                send_packet(body, 1'b0);
            end
            else
            begin
                // noise with random flags
                repeat ($urandom_range(1, 10))
                begin
                    item.data_byte  = 8'($urandom_range(0, 255));
                    item.first_byte = ($urandom_range(0, 5) == 0);
                    item.last_byte  = ($urandom_range(0, 5) == 0);
                    offer(item);
                    bytes_offered++;
                end
            end
        end

        idle_until_drained();
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
